// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared codes, field widths and the result record of the bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int CMD_W = 2;
  localparam int BLK_W = 16;
  localparam int CNT_W = 17;
  localparam int STS_W = 2;
  localparam int REG_W = 17;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FORMAT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

  // status codes
  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_FREE = 2'd1;
  localparam logic [STS_W-1:0] STS_RANGE   = 2'd2;

  // configuration register indexes
  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] free_blocks;
    logic             bit_value;
    logic [BLK_W-1:0] granted_block;
    logic [STS_W-1:0] status;
  } res_t;

endpackage

// ===== rtl/bba_first_free.sv =====
// ----------------------------------------------------------------------------
// bba_first_free
// Finds the lowest free block in one map word, block 0 in the top bit.
// ----------------------------------------------------------------------------
module bba_first_free #(
  parameter int MAP_WORD_BITS = 64
) (
  input  logic [MAP_WORD_BITS-1:0]         word,
  output logic                             found,
  output logic [$clog2(MAP_WORD_BITS)-1:0] idx
);

  localparam int IW = $clog2(MAP_WORD_BITS);

  logic [MAP_WORD_BITS-1:0] free_rev;
  logic [MAP_WORD_BITS-1:0] lowest;

  // free_rev[k] is set when block k of the word is free
  always_comb begin
    for (int k = 0; k < MAP_WORD_BITS; k++) begin
      free_rev[k] = ~word[MAP_WORD_BITS-1-k];
    end
  end

  // isolate the lowest set bit
  assign lowest = free_rev & (~free_rev + {{(MAP_WORD_BITS-1){1'b0}}, 1'b1});
  assign found  = |free_rev;

  always_comb begin
    idx = '0;
    for (int k = 0; k < MAP_WORD_BITS; k++) begin
      if (lowest[k]) begin
        idx = idx | IW'(k);
      end
    end
  end

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used/free bitmap held in one synchronous
// memory of MAP_WORD_BITS-bit words, block 0 in the top bit of word 0. One
// command beat gives one result beat. Format walks every map word, writing
// each. Allocate keeps a first-fit pointer below which every word is full;
// it reads from that word on, reading and then testing each word, or answers
// no-free without reading the map when the free count is zero. Release and
// read split the block number into word and bit with a reciprocal multiply;
// release then does one read-modify-write of that word, read only reads it.
// A release or read block number at or above the effective total returns
// out-of-range. The block handles one command at a time; a new command is
// taken while the previous result still waits on the output. After reset a
// clearing pass writes every map word to zero, during which no command is
// taken; configuration writes still are.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS    = 65536,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] command, [17:2] block_number, rest zero

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] status, [17:2] granted_block,
                                  // [18] bit_value, [35:19] free_blocks, rest zero

  input  logic        cfg_we,
  input  logic        cfg_index,  // 0 total_blocks, 1 reserved_blocks
  input  logic [16:0] cfg_wdata
);

  localparam int W         = MAP_WORD_BITS;
  localparam int MAP_DEPTH = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int HW        = $clog2(MAP_DEPTH + 1);
  localparam int SPAN      = MAP_DEPTH * MAP_WORD_BITS;
  localparam int BASE_RAW  = $clog2(SPAN + MAP_WORD_BITS + 1);
  localparam int BASE_W    = (BASE_RAW > 17) ? BASE_RAW : 17;
  localparam int IW        = $clog2(MAP_WORD_BITS);
  localparam int NW        = $clog2(MAP_WORD_BITS + 1);
  localparam int LIMIT     = (NUM_BLOCKS < 65536) ? NUM_BLOCKS : 65536;
  // block number / W as (b * DIV_M) >> DIV_S, low by at most one
  localparam int DIV_S     = 24;
  localparam int DIV_M     = (1 << DIV_S) / MAP_WORD_BITS;
  localparam int MW        = $clog2(DIV_M + 1);
  localparam int PW        = bba_pkg::BLK_W + MW;

  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
  localparam logic [W-1:0] TOP_BIT  = {1'b1, {(W-1){1'b0}}};

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SWEEP = 4'd1;
  localparam logic [3:0] ST_SCRD  = 4'd2;
  localparam logic [3:0] ST_SCCHK = 4'd3;
  localparam logic [3:0] ST_DIV1  = 4'd4;
  localparam logic [3:0] ST_DIV2  = 4'd5;
  localparam logic [3:0] ST_DIV3  = 4'd6;
  localparam logic [3:0] ST_RMW   = 4'd7;
  localparam logic [3:0] ST_RESP  = 4'd8;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [3:0]               state_r, state_nxt;
  logic                     fmt_r, fmt_nxt;          // sweep is a format command
  logic [HW-1:0]            w_r, w_nxt;              // current map word
  logic [BASE_W-1:0]        base_r, base_nxt;        // first block of w_r
  logic [HW-1:0]            hint_r, hint_nxt;        // first word that may be free
  logic [BASE_W-1:0]        hint_base_r, hint_base_nxt;
  logic                     hint_set_r, hint_set_nxt;
  logic [bba_pkg::CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [bba_pkg::REG_W-1:0] total_r, resv_r;
  logic                     out_valid_r, out_valid_nxt;

  logic [bba_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [bba_pkg::BLK_W-1:0] bn_r, bn_nxt;
  logic [PW-1:0]            prod_r, prod_nxt;
  logic [bba_pkg::BLK_W-1:0] q_r, q_nxt;
  logic [IW-1:0]            off_r, off_nxt;
  bba_pkg::res_t            res_r, res_nxt;
  bba_pkg::res_t            out_res_r, out_res_nxt;

  // map memory
  logic [W-1:0]             map_mem [MAP_DEPTH];
  logic [W-1:0]             rd_data_r;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [W-1:0]             mem_wdata;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic [bba_pkg::CMD_W-1:0] in_cmd;
  logic [bba_pkg::BLK_W-1:0] in_bn;
  logic [bba_pkg::CNT_W-1:0] eff_total;
  logic [bba_pkg::CNT_W-1:0] eff_resv;
  logic [BASE_W-1:0]        total_ext, sweep_r_ext, base_end;
  logic [NW-1:0]            part_n;
  logic [W-1:0]             fmt_word;
  logic                     ff_found;
  logic [IW-1:0]            ff_idx;
  logic [W-1:0]             alloc_mask, rmw_mask;
  logic [BASE_W-1:0]        grant_blk;
  logic [bba_pkg::CNT_W-1:0] qw, rem;
  logic [bba_pkg::BLK_W-1:0] q_fix;
  logic [bba_pkg::CNT_W-1:0] qw_fix, rem_fix;
  logic                     out_free;

  assign in_cmd = in_tdata[1:0];
  assign in_bn  = in_tdata[17:2];

  // total limited to the map size and to what a 16-bit block number names
  assign eff_total = (total_r > bba_pkg::CNT_W'(LIMIT)) ? bba_pkg::CNT_W'(LIMIT) : total_r;
  assign eff_resv  = (resv_r < eff_total) ? resv_r : eff_total;
  assign total_ext = BASE_W'(eff_total);

  // format word: blocks below the reserved count are used
  assign sweep_r_ext = fmt_r ? BASE_W'(eff_resv) : '0;
  assign base_end    = base_r + BASE_W'(W);
  assign part_n      = NW'(sweep_r_ext - base_r);

  always_comb begin
    if (sweep_r_ext >= base_end) begin
      fmt_word = ALL_ONES;
    end else if (sweep_r_ext <= base_r) begin
      fmt_word = '0;
    end else begin
      fmt_word = ~(ALL_ONES >> part_n);
    end
  end

  bba_first_free #(
    .MAP_WORD_BITS(MAP_WORD_BITS)
  ) u_first_free (
    .word  (rd_data_r),
    .found (ff_found),
    .idx   (ff_idx)
  );

  assign alloc_mask = TOP_BIT >> ff_idx;
  assign rmw_mask   = TOP_BIT >> off_r;
  assign grant_blk  = base_r + BASE_W'(ff_idx);

  // word/bit split correction step
  assign qw  = bba_pkg::CNT_W'(32'(q_r) * 32'(W));
  assign rem = bba_pkg::CNT_W'(bn_r) - qw;

  always_comb begin
    if (rem >= bba_pkg::CNT_W'(W)) begin
      q_fix   = q_r + 16'd1;
      qw_fix  = qw + bba_pkg::CNT_W'(W);
      rem_fix = rem - bba_pkg::CNT_W'(W);
    end else begin
      q_fix   = q_r;
      qw_fix  = qw;
      rem_fix = rem;
    end
  end

  assign out_free = ~out_valid_r | out_tready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    fmt_nxt       = fmt_r;
    w_nxt         = w_r;
    base_nxt      = base_r;
    hint_nxt      = hint_r;
    hint_base_nxt = hint_base_r;
    hint_set_nxt  = hint_set_r;
    free_cnt_nxt  = free_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    bn_nxt        = bn_r;
    prod_nxt      = prod_r;
    q_nxt         = q_r;
    off_nxt       = off_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = w_r[AW-1:0];
    mem_wdata     = fmt_word;
    mem_raddr     = w_r[AW-1:0];

    // drop the output beat once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = in_cmd;
          bn_nxt  = in_bn;
          res_nxt = '{free_blocks: free_cnt_r, bit_value: 1'b0,
                      granted_block: '0, status: bba_pkg::STS_OK};
          unique case (in_cmd)
            bba_pkg::CMD_FORMAT: begin
              fmt_nxt       = 1'b1;
              w_nxt         = '0;
              base_nxt      = '0;
              hint_set_nxt  = 1'b0;
              hint_nxt      = HW'(MAP_DEPTH);
              hint_base_nxt = BASE_W'(SPAN);
              state_nxt     = ST_SWEEP;
            end
            bba_pkg::CMD_ALLOC: begin
              if (free_cnt_r == '0) begin
                res_nxt.status = bba_pkg::STS_NO_FREE;
                state_nxt      = ST_RESP;
              end else begin
                w_nxt     = hint_r;
                base_nxt  = hint_base_r;
                state_nxt = ST_SCRD;
              end
            end
            default: begin
              if (bba_pkg::CNT_W'(in_bn) >= eff_total) begin
                res_nxt.status = bba_pkg::STS_RANGE;
                state_nxt      = ST_RESP;
              end else begin
                state_nxt = ST_DIV1;
              end
            end
          endcase
        end
      end

      ST_SWEEP: begin
        mem_we = 1'b1;
        // first word left not full becomes the first-fit pointer
        if (!hint_set_r && (fmt_word != ALL_ONES)) begin
          hint_set_nxt  = 1'b1;
          hint_nxt      = w_r;
          hint_base_nxt = base_r;
        end
        w_nxt    = w_r + HW'(1);
        base_nxt = base_end;
        if (w_r == HW'(MAP_DEPTH - 1)) begin
          if (fmt_r) begin
            free_cnt_nxt        = eff_total - eff_resv;
            res_nxt.free_blocks = eff_total - eff_resv;
            state_nxt           = ST_RESP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_SCRD: begin
        // past the last word that holds a block in range
        if (base_r >= total_ext) begin
          res_nxt.status = bba_pkg::STS_NO_FREE;
          state_nxt      = ST_RESP;
        end else begin
          state_nxt = ST_SCCHK;
        end
      end

      ST_SCCHK: begin
        if (!ff_found) begin
          // full word: advance scan and pointer together
          w_nxt         = w_r + HW'(1);
          base_nxt      = base_end;
          hint_nxt      = w_r + HW'(1);
          hint_base_nxt = base_end;
          state_nxt     = ST_SCRD;
        end else if (grant_blk >= total_ext) begin
          res_nxt.status = bba_pkg::STS_NO_FREE;
          state_nxt      = ST_RESP;
        end else begin
          mem_we                = 1'b1;
          mem_wdata             = rd_data_r | alloc_mask;
          free_cnt_nxt          = free_cnt_r - bba_pkg::CNT_W'(1);
          res_nxt.free_blocks   = free_cnt_r - bba_pkg::CNT_W'(1);
          res_nxt.granted_block = grant_blk[bba_pkg::BLK_W-1:0];
          state_nxt             = ST_RESP;
        end
      end

      ST_DIV1: begin
        prod_nxt  = PW'(bn_r) * PW'(DIV_M);
        state_nxt = ST_DIV2;
      end

      ST_DIV2: begin
        q_nxt     = bba_pkg::BLK_W'(prod_r >> DIV_S);
        state_nxt = ST_DIV3;
      end

      ST_DIV3: begin
        w_nxt     = HW'(q_fix);
        base_nxt  = BASE_W'(qw_fix);
        off_nxt   = IW'(rem_fix);
        mem_raddr = AW'(q_fix);
        state_nxt = ST_RMW;
      end

      ST_RMW: begin
        if (cmd_r == bba_pkg::CMD_RELEASE) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data_r & ~rmw_mask;
          if (w_r < hint_r) begin
            hint_nxt      = w_r;
            hint_base_nxt = base_r;
          end
          if (free_cnt_r < eff_total) begin
            free_cnt_nxt        = free_cnt_r + bba_pkg::CNT_W'(1);
            res_nxt.free_blocks = free_cnt_r + bba_pkg::CNT_W'(1);
          end
        end else begin
          res_nxt.bit_value = |(rd_data_r & rmw_mask);
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        // hold the result until the output register is free
        if (out_free) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      fmt_r       <= 1'b0;
      w_r         <= '0;
      base_r      <= '0;
      hint_r      <= '0;
      hint_base_r <= '0;
      hint_set_r  <= 1'b0;
      free_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      total_r     <= bba_pkg::REG_W'(65536);
      resv_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      fmt_r       <= fmt_nxt;
      w_r         <= w_nxt;
      base_r      <= base_nxt;
      hint_r      <= hint_nxt;
      hint_base_r <= hint_base_nxt;
      hint_set_r  <= hint_set_nxt;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == bba_pkg::REG_TOTAL)) begin
        total_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == bba_pkg::REG_RESERVED)) begin
        resv_r <= cfg_wdata;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    bn_r      <= bn_nxt;
    prod_r    <= prod_nxt;
    q_r       <= q_nxt;
    off_r     <= off_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  // map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= map_mem[mem_raddr];
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_res_r.free_blocks, out_res_r.bit_value,
                       out_res_r.granted_block, out_res_r.status};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |->
      (32'(hint_base_r) == 32'(hint_r) * 32'(W)))
    else $error("first-fit pointer and its block base disagree");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    hint_r <= HW'(MAP_DEPTH))
    else $error("first-fit pointer beyond the map");

  a_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != ST_IDLE))
    else $error("command finished without a result step");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RESP))
    else $error("result beat raised outside the response step");

endmodule

// ===== verif/bitmap_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_tb
// Self-checking bench for the first-fit bitmap allocator. A behavioral copy of
// the used/free map and the free count predicts the result of every accepted
// command beat; a checker compares each result beat field by field in order.
// Directed tests cover reset state, saturation, reserved areas wider than the
// total and a lowered total; random phases then sweep many total and reserved settings.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_tb;

  localparam int NUM_BLOCKS    = 65536;
  localparam int MAP_WORD_BITS = 64;
  localparam int BLK_SPACE     = 1 << bba_pkg::BLK_W;   // blocks a block number can name
  localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  // Slowest single command: an allocate that walks every map word, reading and
  // testing each. The watchdog allows many times that plus the post-reset clear.
  localparam int SLOWEST_CMD   = 2 * MAP_WORDS + 16;
  localparam int STALL_LIMIT   = 10 * SLOWEST_CMD + MAP_WORDS;
  localparam int SHOWN_ERRORS  = 10;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;     // [1:0] command, [17:2] block_number, rest zero
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;    // [1:0] status, [17:2] granted_block,
                             // [18] bit_value, [35:19] free_blocks, rest zero
  logic        cfg_we;
  logic        cfg_index;
  logic [16:0] cfg_wdata;

  bitmap_block_allocator #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Allocator shadow: one bit per block (1 used), the free count and both
  // registers as last written.
  // --------------------------------------------------------------------------
  bit          blk_used [BLK_SPACE];
  int unsigned free_cnt;
  int unsigned total_reg;
  int unsigned reserved_reg;

  bba_pkg::res_t pending_results[$];   // predicted results, oldest first
  int unsigned   granted_hist[$];      // recent grants, reused as release targets

  int          mismatch_count;
  int          cmd_seen [4];
  int          no_free_seen;
  int          out_of_range_seen;
  int          beats_checked;
  int          idle_cycles;
  bit          in_burst;
  bit          out_burst;

  // Total in effect: the register clamped to the map size and the number
  // space of a 16-bit block number.
  function automatic int unsigned eff_total();
    int unsigned lim;
    lim = total_reg;
    if (lim > NUM_BLOCKS) lim = NUM_BLOCKS;
    if (lim > BLK_SPACE) lim = BLK_SPACE;
    return lim;
  endfunction

  // Apply one command to the shadow and return the result it must produce.
  function automatic bba_pkg::res_t apply_command(logic [bba_pkg::CMD_W-1:0] cmd,
                                                  logic [bba_pkg::BLK_W-1:0] bn);
    int unsigned   lim;
    int unsigned   rsv;
    int unsigned   b;
    bit            found;
    bba_pkg::res_t r;
    lim   = eff_total();
    r     = '0;
    found = 1'b0;
    case (cmd)
      bba_pkg::CMD_FORMAT: begin
        rsv = (reserved_reg < lim) ? reserved_reg : lim;
        for (b = 0; b < BLK_SPACE; b++) blk_used[b] = (b < rsv);
        free_cnt = lim - rsv;
      end
      bba_pkg::CMD_ALLOC: begin
        // Empty count: no scan at all. Otherwise first fit below the total;
        // the count can claim free blocks that the map does not have.
        if (free_cnt != 0) begin
          for (b = 0; b < lim && !found; b++) begin
            if (!blk_used[b]) begin
              found = 1'b1;
              r.granted_block = b[bba_pkg::BLK_W-1:0];
            end
          end
        end
        if (!found) begin
          r.status = bba_pkg::STS_NO_FREE;
        end else begin
          blk_used[r.granted_block] = 1'b1;
          free_cnt--;
        end
      end
      default: begin
        if (bn >= lim) begin
          r.status = bba_pkg::STS_RANGE;
        end else if (cmd == bba_pkg::CMD_RELEASE) begin
          // Count rises even for an already free block; saturate at the total
          // and leave a count that is above a lowered total alone.
          blk_used[bn] = 1'b0;
          if (free_cnt < lim) free_cnt++;
        end else begin
          r.bit_value = blk_used[bn];
        end
      end
    endcase
    r.free_blocks = free_cnt[bba_pkg::CNT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles in which no beat moves on either side; a hang ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("bitmap_block_allocator_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random backpressure, with stretches of none.
  // --------------------------------------------------------------------------
  initial begin : out_ready_driver
    int unsigned stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      // hold ready until a beat goes through
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : result_checker
    bba_pkg::res_t got;
    bba_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = bba_pkg::res_t'(out_tdata[35:0]);
      beats_checked++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
          $display("%0t: stray beat: status %0d block %0d bit %0d free %0d",
                   $realtime, got.status, got.granted_block, got.bit_value,
                   got.free_blocks);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.granted_block !== want.granted_block ||
            got.bit_value !== want.bit_value || got.free_blocks !== want.free_blocks) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRORS) begin
            $display("%0t: beat %0d expected status %0d block %0d bit %0d free %0d",
                     $realtime, beats_checked, want.status, want.granted_block,
                     want.bit_value, want.free_blocks);
            $display("%0t: beat %0d actual   status %0d block %0d bit %0d free %0d",
                     $realtime, beats_checked, got.status, got.granted_block,
                     got.bit_value, got.free_blocks);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  // Send one command beat after a random gap and predict its result at the
  // accepting edge. Valid stays high on return so back-to-back beats never
  // drop it within one step.
  task automatic send_cmd(logic [bba_pkg::CMD_W-1:0] cmd, logic [bba_pkg::BLK_W-1:0] bn);
    int unsigned   gap;
    bba_pkg::res_t want;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, bn, cmd};
    do @(posedge clk); while (!in_tready);
    want = apply_command(cmd, bn);
    pending_results.push_back(want);
    cmd_seen[cmd]++;
    if (want.status == bba_pkg::STS_NO_FREE) no_free_seen++;
    if (want.status == bba_pkg::STS_RANGE) out_of_range_seen++;
    if (cmd == bba_pkg::CMD_ALLOC && want.status == bba_pkg::STS_OK) begin
      granted_hist.push_back(want.granted_block);
      if (granted_hist.size() > 64) void'(granted_hist.pop_front());
    end
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // One register write; call only with the block idle.
  task automatic write_reg(logic idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[16:0];
    @(posedge clk);
    if (idx == bba_pkg::REG_TOTAL) total_reg = value;
    else reserved_reg = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Block number for release or read: mostly in range, some recent grants,
  // some right at the boundary and some anywhere in the 16-bit space.
  function automatic logic [bba_pkg::BLK_W-1:0] pick_block();
    int unsigned lim;
    int unsigned sel;
    lim = eff_total();
    sel = $urandom_range(0, 99);
    if (sel < 55) return bba_pkg::BLK_W'($urandom_range(0, lim - 1));
    if (sel < 80 && granted_hist.size() != 0)
      return bba_pkg::BLK_W'(granted_hist[$urandom_range(0, granted_hist.size() - 1)]);
    if (sel < 88) return bba_pkg::BLK_W'((sel[0] || lim >= BLK_SPACE) ? lim - 1 : lim);
    return bba_pkg::BLK_W'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fresh out of reset: count is zero, map clear, total at its maximum.
  task automatic test_reset_state();
    send_cmd(bba_pkg::CMD_ALLOC, '0);          // empty count -> no free
    send_cmd(bba_pkg::CMD_READ, 16'd0);
    send_cmd(bba_pkg::CMD_READ, 16'hFFFF);     // top block is in range at full total
  endtask

  // Full-size map: first fit, read back, release and count saturation.
  task automatic test_alloc_release();
    send_cmd(bba_pkg::CMD_FORMAT, 16'hFFFF);
    send_cmd(bba_pkg::CMD_ALLOC, '0);
    send_cmd(bba_pkg::CMD_ALLOC, 16'hFFFF);
    send_cmd(bba_pkg::CMD_READ, 16'd0);
    send_cmd(bba_pkg::CMD_RELEASE, 16'd0);
    send_cmd(bba_pkg::CMD_READ, 16'd0);
    send_cmd(bba_pkg::CMD_RELEASE, 16'hFFFF);  // free block: count climbs to the total
    send_cmd(bba_pkg::CMD_RELEASE, 16'hFFFF);  // saturated
  endtask

  // Reserved area larger than the map: everything used, then a count that
  // claims a free block the map no longer has.
  task automatic test_reserved_over_total();
    drain_results();
    write_reg(bba_pkg::REG_TOTAL, 8);
    write_reg(bba_pkg::REG_RESERVED, 65536);
    send_cmd(bba_pkg::CMD_FORMAT, '0);
    send_cmd(bba_pkg::CMD_ALLOC, '0);
    send_cmd(bba_pkg::CMD_READ, 16'd7);
    send_cmd(bba_pkg::CMD_READ, 16'd8);        // first block out of range
    send_cmd(bba_pkg::CMD_RELEASE, 16'hFFFF);
    send_cmd(bba_pkg::CMD_RELEASE, 16'd3);
    send_cmd(bba_pkg::CMD_RELEASE, 16'd3);     // already free, count still rises
    send_cmd(bba_pkg::CMD_ALLOC, '0);
    send_cmd(bba_pkg::CMD_ALLOC, '0);          // count one, no free bit
  endtask

  // Lower the total under a formatted map: the count stays above it.
  task automatic test_lowered_total();
    drain_results();
    write_reg(bba_pkg::REG_TOTAL, 100);
    write_reg(bba_pkg::REG_RESERVED, 0);
    send_cmd(bba_pkg::CMD_FORMAT, '0);
    drain_results();
    write_reg(bba_pkg::REG_TOTAL, 10);
    send_cmd(bba_pkg::CMD_RELEASE, 16'd2);
    send_cmd(bba_pkg::CMD_ALLOC, '0);
    send_cmd(bba_pkg::CMD_READ, 16'd99);
  endtask

  // One random phase: set the registers, format, then a mix of commands with
  // an occasional mid-phase format and a rare full drain.
  task automatic run_map_phase(int unsigned total, int unsigned reserved, int count);
    int unsigned sel;
    drain_results();
    write_reg(bba_pkg::REG_TOTAL, total);
    write_reg(bba_pkg::REG_RESERVED, reserved);
    granted_hist.delete();
    send_cmd(bba_pkg::CMD_FORMAT, bba_pkg::BLK_W'($urandom));
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 3)       send_cmd(bba_pkg::CMD_FORMAT, bba_pkg::BLK_W'($urandom));
      else if (sel < 45) send_cmd(bba_pkg::CMD_ALLOC, bba_pkg::BLK_W'($urandom));
      else if (sel < 75) send_cmd(bba_pkg::CMD_RELEASE, pick_block());
      else               send_cmd(bba_pkg::CMD_READ, pick_block());
      if ($urandom_range(0, 99) == 0) drain_results();
    end
  endtask

  task automatic test_random_phases();
    int unsigned spot_total;
    run_map_phase(64, 0, 100);        // exactly one map word
    run_map_phase(65, 3, 100);        // spills one block into the next word
    run_map_phase(200, 17, 100);
    run_map_phase(1, 0, 40);          // smallest map
    run_map_phase(1000, 990, 90);
    run_map_phase(130, 200, 60);      // reserved beyond the total
    run_map_phase(65536, 65536, 30);  // fully reserved, largest map
    run_map_phase(65536, 65500, 30);  // long first-fit walk
    spot_total = $urandom_range(2, 600);
    run_map_phase(spot_total, $urandom_range(0, spot_total + 8), 100);
    run_map_phase(65536, 0, 100);
    spot_total = $urandom_range(1, 65536);
    run_map_phase(spot_total, $urandom_range(0, 64), 50);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_index    = bba_pkg::REG_TOTAL;
    cfg_wdata    = '0;
    in_burst     = 1'b0;
    // shadow matches the block's reset state
    free_cnt     = 0;
    total_reg    = 65536;
    reserved_reg = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_alloc_release();
    test_reserved_over_total();
    test_lowered_total();
    test_random_phases();

    // wait out the last results, then watch for stray beats
    drain_results();
    repeat (SLOWEST_CMD + 64) @(posedge clk);

    $display("covered %0d formats, %0d allocates, %0d releases, %0d reads",
             cmd_seen[bba_pkg::CMD_FORMAT], cmd_seen[bba_pkg::CMD_ALLOC],
             cmd_seen[bba_pkg::CMD_RELEASE], cmd_seen[bba_pkg::CMD_READ]);
    $display("%0d result beats checked, %0d no-free and %0d out-of-range among them",
             beats_checked, no_free_seen, out_of_range_seen);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("bitmap_block_allocator_tb passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               mismatch_count, pending_results.size());
      $display("bitmap_block_allocator_tb failed");
    end
    $finish;
  end

endmodule

// ===== bitmap_block_allocator.f =====
rtl/bba_pkg.sv
rtl/bba_first_free.sv
rtl/bitmap_block_allocator.sv
verif/bitmap_block_allocator_tb.sv
